[design/qwt_pkg.sv]
// qwt_pkg: result kinds and the result item type for the quote aware word tokenizer
// no dependencies; qwt_scan, qwt_rfifo and the top module refer to it by scoped names
package qwt_pkg;

	localparam logic [2:0] KIND_TOKEN         = 3'd0;
	localparam logic [2:0] KIND_END_OK        = 3'd1;
	localparam logic [2:0] KIND_QUOTE_IN_WORD = 3'd2;
	localparam logic [2:0] KIND_UNCLOSED      = 3'd3;
	localparam logic [2:0] KIND_TOO_LONG      = 3'd4;

	localparam logic [7:0] SQUOTE = 8'h27;
	localparam logic [7:0] DQUOTE = 8'h22;

	localparam int RESULT_DEPTH = 4;
	localparam int RESULT_IDX_BITS = $clog2(RESULT_DEPTH);

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] token_begin;
		logic [15:0] token_length;
		logic [15:0] token_count;
		logic        last;
	} result_t;

	// what one scan step produces: zero, one or two result items
	typedef struct packed {
		logic    r0_valid;
		logic    r1_valid;
		result_t r0;
		result_t r1;
	} step_out_t;

endpackage

[design/qwt_ifs.sv]
// qwt_ifs: valid/ready channel interfaces for bytes in and result items out
// no dependencies; the result kind width is written out here as three bits
interface qwt_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       string_end;

	modport source (output valid, output ch, output string_end, input ready);
	modport sink (input valid, input ch, input string_end, output ready);
endinterface

interface qwt_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [15:0] token_begin;
	logic [15:0] token_length;
	logic [15:0] token_count;
	logic        last;

	modport source (output valid, output kind, output token_begin, output token_length,
		output token_count, output last, input ready);
	modport sink (input valid, input kind, input token_begin, input token_length,
		input token_count, input last, output ready);
endinterface

[design/qwt_scan.sv]
// qwt_scan: per-string scan state and the one-byte step logic
// depends on qwt_pkg for result kinds and the step output struct
module qwt_scan #(
	parameter int OFFSET_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          ch,
	input  logic                string_end,
	output qwt_pkg::step_out_t  out
);

	localparam logic [1:0] MODE_BETWEEN = 2'd0;
	localparam logic [1:0] MODE_WORD    = 2'd1;
	localparam logic [1:0] MODE_SQUOTE  = 2'd2;
	localparam logic [1:0] MODE_DQUOTE  = 2'd3;

	localparam logic [OFFSET_BITS-1:0] LIMIT = {OFFSET_BITS{1'b1}};

	logic [1:0]             mode_q, mode_n;
	logic [OFFSET_BITS-1:0] pos_q, pos_n;
	logic [OFFSET_BITS-1:0] start_q, start_n;
	logic [OFFSET_BITS-1:0] count_q, count_n;
	logic                   failed_q, failed_n;

	logic                   is_space;
	logic [OFFSET_BITS-1:0] count_inc;
	logic [OFFSET_BITS-1:0] tok_len;
	logic [31:0]            start_w, len_w, inc_w, count_w;

	assign is_space  = ((ch >= 8'd9) && (ch <= 8'd13)) || (ch == 8'd32);
	assign count_inc = count_q + 1'b1;
	assign tok_len   = pos_q - start_q;
	// report offsets in their low 16 bits, zero filled when narrower
	assign start_w   = 32'(start_q);
	assign len_w     = 32'(tok_len);
	assign inc_w     = 32'(count_inc);
	assign count_w   = 32'(count_q);

	always_comb begin
		qwt_pkg::result_t tok, endr, err;
		tok.kind         = qwt_pkg::KIND_TOKEN;
		tok.token_begin  = start_w[15:0];
		tok.token_length = len_w[15:0];
		tok.token_count  = inc_w[15:0];
		tok.last         = 1'b0;
		endr.kind         = qwt_pkg::KIND_END_OK;
		endr.token_begin  = '0;
		endr.token_length = '0;
		endr.token_count  = count_w[15:0];
		endr.last         = 1'b1;
		err.kind         = qwt_pkg::KIND_TOO_LONG;
		err.token_begin  = '0;
		err.token_length = '0;
		err.token_count  = '0;
		err.last         = 1'b1;

		mode_n   = mode_q;
		pos_n    = pos_q;
		start_n  = start_q;
		count_n  = count_q;
		failed_n = failed_q;
		out.r0_valid = 1'b0;
		out.r1_valid = 1'b0;
		out.r0 = tok;
		out.r1 = endr;

		if (string_end) begin
			if (!failed_q) begin
				out.r0_valid = 1'b1;
				if ((mode_q == MODE_SQUOTE) || (mode_q == MODE_DQUOTE)) begin
					err.kind = qwt_pkg::KIND_UNCLOSED;
					out.r0 = err;
				end else if (mode_q == MODE_WORD) begin
					// open word goes out first, end item carries the new count
					out.r1_valid = 1'b1;
					endr.token_count = inc_w[15:0];
					out.r1 = endr;
				end else begin
					out.r0 = endr;
				end
			end
			mode_n   = MODE_BETWEEN;
			pos_n    = '0;
			start_n  = '0;
			count_n  = '0;
			failed_n = 1'b0;
		end else if (!failed_q) begin
			if (pos_q == LIMIT) begin
				failed_n = 1'b1;
				out.r0_valid = 1'b1;
				out.r0 = err;
			end else begin
				pos_n = pos_q + 1'b1;
				unique case (mode_q) inside
					MODE_BETWEEN: begin
						if (!is_space) begin
							if (ch == qwt_pkg::SQUOTE) begin
								mode_n  = MODE_SQUOTE;
								start_n = pos_q + 1'b1;
							end else if (ch == qwt_pkg::DQUOTE) begin
								mode_n  = MODE_DQUOTE;
								start_n = pos_q + 1'b1;
							end else begin
								mode_n  = MODE_WORD;
								start_n = pos_q;
							end
						end
					end
					MODE_SQUOTE, MODE_DQUOTE: begin
						if (((mode_q == MODE_SQUOTE) && (ch == qwt_pkg::SQUOTE)) ||
							((mode_q == MODE_DQUOTE) && (ch == qwt_pkg::DQUOTE))) begin
							out.r0_valid = 1'b1;
							count_n = count_inc;
							mode_n  = MODE_BETWEEN;
						end
					end
					default: begin
						if (is_space) begin
							out.r0_valid = 1'b1;
							count_n = count_inc;
							mode_n  = MODE_BETWEEN;
						end else if ((ch == qwt_pkg::SQUOTE) || (ch == qwt_pkg::DQUOTE)) begin
							failed_n = 1'b1;
							err.kind = qwt_pkg::KIND_QUOTE_IN_WORD;
							out.r0_valid = 1'b1;
							out.r0 = err;
						end
					end
				endcase
			end
		end
		if (!step) begin
			out.r0_valid = 1'b0;
			out.r1_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_BETWEEN;
			pos_q    <= '0;
			start_q  <= '0;
			count_q  <= '0;
			failed_q <= 1'b0;
		end else if (step) begin
			mode_q   <= mode_n;
			pos_q    <= pos_n;
			start_q  <= start_n;
			count_q  <= count_n;
			failed_q <= failed_n;
		end
	end

endmodule

[design/qwt_rfifo.sv]
// qwt_rfifo: small result queue, up to two pushes and one pop per cycle
// depends on qwt_pkg for the result item type and queue depth
module qwt_rfifo (
	input  logic                clk,
	input  logic                arst_n,
	input  qwt_pkg::step_out_t  push,
	input  logic                pop,
	output qwt_pkg::result_t    head,
	output logic                not_empty,
	output logic                room
);

	localparam int IB = qwt_pkg::RESULT_IDX_BITS;

	qwt_pkg::result_t mem_q [qwt_pkg::RESULT_DEPTH];
	logic [IB-1:0]    wr_q, rd_q;
	logic [IB:0]      cnt_q;
	logic             do_pop;

	assign not_empty = (cnt_q != '0);
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_q];
	// two free slots needed, a step can make two items
	assign room      = (cnt_q <= (IB+1)'(qwt_pkg::RESULT_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.r0_valid) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.r1_valid) begin
			mem_q[wr_q + 1'b1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + IB'(push.r0_valid) + IB'(push.r1_valid);
			rd_q  <= rd_q + IB'(do_pop);
			cnt_q <= cnt_q + (IB+1)'(push.r0_valid) + (IB+1)'(push.r1_valid)
				- (IB+1)'(do_pop);
		end
	end

endmodule

[design/quote_aware_word_tokenizer.sv]
// quote_aware_word_tokenizer: splits a byte stream into whitespace or quote delimited tokens
// results: an end item with an open word gives two result items
// throughput: one byte item per cycle while the result queue has room for two items
// reset: arst_n clears the input stage, the scan state and the result queue at once
// depends on qwt_pkg, qwt_ifs, qwt_scan and qwt_rfifo
module quote_aware_word_tokenizer #(
	parameter int OFFSET_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	qwt_text_if.sink       text,
	qwt_result_if.source   result
);

	// input stage: holds one accepted item until the queue has room for its results
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       end_s1;

	logic                advance;
	logic                room;
	logic                not_empty;
	qwt_pkg::step_out_t  step_out;
	qwt_pkg::result_t    head;

	// stage moves on only when two queue slots are free
	assign advance    = valid_s1 && room;
	// take a new item whenever the stage is empty or leaving this cycle
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			ch_s1  <= text.ch;
			end_s1 <= text.string_end;
		end
	end

	// scan state machine, one step per item leaving the input stage
	qwt_scan #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.ch         (ch_s1),
		.string_end (end_s1),
		.out        (step_out)
	);

	// result queue decouples the output side, so a stalled sink does not stop intake at once
	qwt_rfifo u_rfifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step_out),
		.pop       (result.ready),
		.head      (head),
		.not_empty (not_empty),
		.room      (room)
	);

	assign result.valid        = not_empty;
	assign result.kind         = head.kind;
	assign result.token_begin  = head.token_begin;
	assign result.token_length = head.token_length;
	assign result.token_count  = head.token_count;
	assign result.last         = head.last;

endmodule
